### design/hsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HSP saturation package
// Shared types, fixed-point constants and the square-root step function.
// ----------------------------------------------------------------------------
package hsp_pkg;

	// Channel and register widths.
	localparam int CH_W     = 8;
	localparam int LEVEL_W  = 9;
	localparam int SUM_W    = 32;
	localparam int P_W      = 16;
	localparam int REM_W    = 19;
	localparam int BEAT_W   = 4 * CH_W;

	// Q16 brightness weights; they sum to one.
	localparam logic [15:0] W_R = 16'd19595;
	localparam logic [15:0] W_G = 16'd38470;
	localparam logic [15:0] W_B = 16'd7471;

	// Square root: two result bits per stage, sixteen result bits in all.
	localparam int SQRT_STAGES = P_W / 2;

	// Channel scaling: result = N / 25600, clamped to the channel range.
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 9'd100;
	localparam logic [6:0]         SCALE_PCT   = 7'd100;
	localparam logic [27:0]        CLAMP_N     = 28'd6553600;
	localparam logic [13:0]        DIV_K       = 14'd10486;
	localparam int                 DIV_SHIFT   = 18;
	localparam logic [CH_W-1:0]    CH_MAX      = 8'hFF;
	localparam logic [CH_W-1:0]    CH_ZERO     = 8'h00;

	// One RGBA pixel; red sits in the lowest bits.
	typedef struct packed {
		logic [CH_W-1:0] alpha;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pix_t;

	// Partial root and remainder of the digit-by-digit square root.
	typedef struct packed {
		logic [P_W-1:0]   root;
		logic [REM_W-1:0] rem;
	} sqrt_t;

	// One digit of the restoring square root: brings in two radicand bits.
	// The remainder never exceeds twice the root, so its top two bits are zero.
	function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [1:0] pair);
		logic [REM_W-1:0] shifted;
		logic [REM_W-1:0] trial;
		sqrt_t            nxt;
		shifted = {cur.rem[REM_W-3:0], pair};
		trial   = {1'b0, cur.root, 2'b01};
		if (shifted >= trial) begin
			nxt.rem  = shifted - trial;
			nxt.root = {cur.root[P_W-2:0], 1'b1};
		end else begin
			nxt.rem  = shifted;
			nxt.root = {cur.root[P_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage
`default_nettype wire

### design/hsp_luma.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HSP weighted square sum
// Three stages: channel squares, weighted products, and their sum.
// ----------------------------------------------------------------------------
module hsp_luma (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  ce,
	input  wire                  in_valid,
	input  wire hsp_pkg::pix_t   pix_in,
	output logic                 out_valid,
	output hsp_pkg::pix_t        pix_out,
	output logic [hsp_pkg::SUM_W-1:0] sum_out
);
	import hsp_pkg::*;

	logic        v_s1, v_s2, v_s3;
	pix_t        pix_s1, pix_s2, pix_s3;
	logic [15:0] sq_r_s1, sq_g_s1, sq_b_s1;
	logic [31:0] wr_s2, wg_s2, wb_s2;
	logic [SUM_W-1:0] sum_s3;

	// Valid bits follow the data through the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Squares, then the Q16 weights, then the sum; the sum stays below 2^32.
	always_ff @(posedge clk) begin
		if (ce) begin
			pix_s1  <= pix_in;
			sq_r_s1 <= {8'd0, pix_in.red} * {8'd0, pix_in.red};
			sq_g_s1 <= {8'd0, pix_in.green} * {8'd0, pix_in.green};
			sq_b_s1 <= {8'd0, pix_in.blue} * {8'd0, pix_in.blue};

			pix_s2  <= pix_s1;
			wr_s2   <= {16'd0, W_R} * {16'd0, sq_r_s1};
			wg_s2   <= {16'd0, W_G} * {16'd0, sq_g_s1};
			wb_s2   <= {16'd0, W_B} * {16'd0, sq_b_s1};

			pix_s3  <= pix_s2;
			sum_s3  <= wr_s2 + wg_s2 + wb_s2;
		end
	end

	assign out_valid = v_s3;
	assign pix_out   = pix_s3;
	assign sum_out   = sum_s3;

endmodule
`default_nettype wire

### design/hsp_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HSP pipelined square root
// Integer square root rounded down, two result bits per stage.
// ----------------------------------------------------------------------------
module hsp_sqrt (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       ce,
	input  wire                       in_valid,
	input  wire hsp_pkg::pix_t        pix_in,
	input  wire [hsp_pkg::SUM_W-1:0]  sum_in,
	output logic                      out_valid,
	output hsp_pkg::pix_t             pix_out,
	output logic [hsp_pkg::P_W-1:0]   root_out
);
	import hsp_pkg::*;

	logic             v_s   [SQRT_STAGES];
	pix_t             pix_s [SQRT_STAGES];
	logic [SUM_W-1:0] rad_s [SQRT_STAGES];
	sqrt_t            sq_s  [SQRT_STAGES];

	genvar i;
	generate
		for (i = 0; i < SQRT_STAGES; i++) begin : g_stage
			logic             v_prev;
			pix_t             pix_prev;
			logic [SUM_W-1:0] rad_prev;
			sqrt_t            sq_prev;
			sqrt_t            sq_mid;
			sqrt_t            sq_next;

			// The first stage starts from an empty root and remainder.
			if (i == 0) begin : g_first
				assign v_prev   = in_valid;
				assign pix_prev = pix_in;
				assign rad_prev = sum_in;
				assign sq_prev  = '0;
			end else begin : g_next
				assign v_prev   = v_s[i-1];
				assign pix_prev = pix_s[i-1];
				assign rad_prev = rad_s[i-1];
				assign sq_prev  = sq_s[i-1];
			end

			// Two digits per stage, taken from the top of the radicand.
			assign sq_mid  = sqrt_step(sq_prev, rad_prev[SUM_W-1:SUM_W-2]);
			assign sq_next = sqrt_step(sq_mid, rad_prev[SUM_W-3:SUM_W-4]);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i] <= 1'b0;
				end else if (ce) begin
					v_s[i] <= v_prev;
				end
			end

			always_ff @(posedge clk) begin
				if (ce) begin
					pix_s[i] <= pix_prev;
					rad_s[i] <= {rad_prev[SUM_W-5:0], 4'b0000};
					sq_s[i]  <= sq_next;
				end
			end
		end
	endgenerate

	assign out_valid = v_s[SQRT_STAGES-1];
	assign pix_out   = pix_s[SQRT_STAGES-1];
	assign root_out  = sq_s[SQRT_STAGES-1].root;

endmodule
`default_nettype wire

### design/hsp_adjust.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HSP channel adjust
// Four stages: P + (C - P) * level / 100 in Q8, truncated and clamped to 0..255.
// ----------------------------------------------------------------------------
module hsp_adjust (
	input  wire                          clk,
	input  wire                          ce,
	input  wire [hsp_pkg::CH_W-1:0]      chan_in,
	input  wire [hsp_pkg::P_W-1:0]       bright_in,
	input  wire [hsp_pkg::LEVEL_W-1:0]   level,
	output logic [hsp_pkg::CH_W-1:0]     chan_out
);
	import hsp_pkg::*;

	logic signed [17:0] diff_s1;
	logic [22:0]        p100_s1;
	logic signed [27:0] prod_s2;
	logic [22:0]        p100_s2;
	logic [28:0]        n_sum;
	logic               neg_s3, big_s3;
	logic [12:0]        m_s3;
	logic [26:0]        q_prod;
	logic [CH_W-1:0]    chan_s4;

	// Scaled numerator N, kept as two's complement bits.
	assign n_sum = {prod_s2[27], prod_s2} + {6'd0, p100_s2};

	// N / 25600 as (N / 1024) / 25, the last by reciprocal; exact below 6400.
	assign q_prod = {14'd0, m_s3} * {13'd0, DIV_K};

	always_ff @(posedge clk) begin
		if (ce) begin
			// Offset from brightness and the scaled brightness.
			diff_s1 <= $signed({2'b00, chan_in, 8'd0}) - $signed({2'b00, bright_in});
			p100_s1 <= {7'd0, bright_in} * {16'd0, SCALE_PCT};

			// Offset times the level.
			prod_s2 <= diff_s1 * $signed({1'b0, level});
			p100_s2 <= p100_s1;

			// Clamp decisions and the coarse quotient.
			neg_s3  <= n_sum[28];
			big_s3  <= !n_sum[28] && (n_sum[27:0] >= CLAMP_N);
			m_s3    <= n_sum[22:10];

			// Final channel value.
			if (neg_s3) begin
				chan_s4 <= CH_ZERO;
			end else if (big_s3) begin
				chan_s4 <= CH_MAX;
			end else begin
				chan_s4 <= q_prod[DIV_SHIFT+CH_W-1:DIV_SHIFT];
			end
		end
	end

	assign chan_out = chan_s4;

endmodule
`default_nettype wire

### design/hsp_pixel_saturation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HSP pixel saturation
// Changes the saturation of RGBA pixels around their perceived brightness.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ group as one 32-bit beat and leave on the m_ group in
// the same order, one result beat for each input beat. The cfg_ channel writes
// the saturation level in percent; it is always ready and should be written
// only while no pixel is in flight.
// From an accepted input beat to its output beat, three stages form the
// weighted square sum, eight stages take its square root two bits at a time,
// and four stages scale and clamp each channel.
// Throughput is one pixel per clock. The whole pipeline advances together;
// when the receiver holds m_tready low with a result waiting, every stage
// holds and s_tready drops, so nothing is lost or repeated. While the output
// register is empty, input beats keep being taken.
// Reset clears all valid bits and sets the level to 100 (pixels unchanged).
// ----------------------------------------------------------------------------
module hsp_pixel_saturation (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// s_tdata: red_in [7:0], green_in [15:8], blue_in [23:16], alpha_in [31:24]
	input  wire [hsp_pkg::BEAT_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// m_tdata: red_out [7:0], green_out [15:8], blue_out [23:16], alpha_out [31:24]
	output logic [hsp_pkg::BEAT_W-1:0]   m_tdata,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [hsp_pkg::LEVEL_W-1:0]   cfg_data
);
	import hsp_pkg::*;

	logic               ce;
	logic [LEVEL_W-1:0] level_q;
	logic               luma_valid, sqrt_valid;
	pix_t               luma_pix, sqrt_pix;
	logic [SUM_W-1:0]   luma_sum;
	logic [P_W-1:0]     bright;
	logic               v_s12, v_s13, v_s14, v_s15;
	logic [CH_W-1:0]    a_s12, a_s13, a_s14, a_s15;
	logic [CH_W-1:0]    red_res, green_res, blue_res;

	// The pipeline moves whenever the output register is free or being taken.
	assign ce       = !v_s15 || m_tready;
	assign s_tready = ce;

	// Saturation level register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RESET;
		end else if (cfg_valid) begin
			level_q <= cfg_data;
		end
	end

	hsp_luma u_luma (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (s_tvalid),
		.pix_in    (pix_t'(s_tdata)),
		.out_valid (luma_valid),
		.pix_out   (luma_pix),
		.sum_out   (luma_sum)
	);

	hsp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (luma_valid),
		.pix_in    (luma_pix),
		.sum_in    (luma_sum),
		.out_valid (sqrt_valid),
		.pix_out   (sqrt_pix),
		.root_out  (bright)
	);

	hsp_adjust u_adj_red (
		.clk       (clk),
		.ce        (ce),
		.chan_in   (sqrt_pix.red),
		.bright_in (bright),
		.level     (level_q),
		.chan_out  (red_res)
	);

	hsp_adjust u_adj_green (
		.clk       (clk),
		.ce        (ce),
		.chan_in   (sqrt_pix.green),
		.bright_in (bright),
		.level     (level_q),
		.chan_out  (green_res)
	);

	hsp_adjust u_adj_blue (
		.clk       (clk),
		.ce        (ce),
		.chan_in   (sqrt_pix.blue),
		.bright_in (bright),
		.level     (level_q),
		.chan_out  (blue_res)
	);

	// Valid bits alongside the four channel-adjust stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (ce) begin
			v_s12 <= sqrt_valid;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	// Alpha is delayed to line up with the adjusted channels.
	always_ff @(posedge clk) begin
		if (ce) begin
			a_s12 <= sqrt_pix.alpha;
			a_s13 <= a_s12;
			a_s14 <= a_s13;
			a_s15 <= a_s14;
		end
	end

	assign m_tvalid = v_s15;
	assign m_tdata  = {a_s15, blue_res, green_res, red_res};

endmodule
`default_nettype wire
